>>> sv/slbs_pkg.sv
// Shared types and field widths for the side-limited box suppression block.
package slbs_pkg;

   localparam int unsigned COORD_W = 14;
   localparam int unsigned SCORE_W = 16;
   localparam int unsigned BOUND_W = 10;
   localparam int unsigned CORNER_W = 16;
   localparam int unsigned AREA_W = 2 * COORD_W;
   localparam int unsigned UNION_W = AREA_W + 1;
   localparam int unsigned PROD_W = SCORE_W + UNION_W;

   localparam int unsigned REQ_DATA_W = 4 * COORD_W + SCORE_W;
   localparam int unsigned RSP_DATA_W = 4 * CORNER_W;
   localparam int unsigned RSP_USER_W = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONF_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IOU_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_BOUNDARY = 2'd2;

   typedef logic signed [CORNER_W-1:0] corner_type;

   typedef struct packed {
      corner_type bottom;
      corner_type right;
      corner_type top;
      corner_type left;
   } box_type;

endpackage

>>> sv/side_limited_box_suppression.sv
// Side-limited greedy box suppression: top level with its sequencer and shared multiplier.
//
// Candidates arrive score-sorted, one per request, and each produces exactly one response
// carrying the box corners, its side and whether it was kept; at most one box is kept per
// image half and the kept set clears after the request marked tlast. The response goes to
// the output register with no overlap test when none is needed (score at or below
// threshold, side already taken, or the other side empty). When the candidate must be
// tested against the box kept on the other side, the sequencer forms its own area, the
// other area and the intersection, and runs the full IoU test only if the two boxes
// overlap. A response held by rsp_tready low stalls the sequencer in its output state.
// The overlap test runs through a single 16 x 29 bit multiplier used up to four times in
// turn (own area, other area, intersection, threshold times union). A new request is
// taken once the sequencer is back in idle, while the previous response may still be
// waiting in the output register. Configuration writes are always taken (csr_ready is
// tied high) and must only be issued while the block is idle.
module side_limited_box_suppression (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // center_x[13:0], center_y[27:14], box_width[41:28], box_height[55:42], score[71:56]
   input  logic [slbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // corner_left[15:0], corner_top[31:16], corner_right[47:32], corner_bottom[63:48]
   output logic [slbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kept[0], side[1]
   output logic [slbs_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slbs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import slbs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_AREA  = 3'd1;
   localparam logic [2:0] S_OTHER = 3'd2;
   localparam logic [2:0] S_INTER = 3'd3;
   localparam logic [2:0] S_UNION = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]          state_ff, state_in;

   logic [SCORE_W-1:0]  conf_thr_ff, iou_thr_ff;
   logic [BOUND_W-1:0]  boundary_ff;

   box_type             left_box_ff, left_box_in, right_box_ff, right_box_in;
   logic                left_taken_ff, left_taken_in, right_taken_ff, right_taken_in;

   box_type             cand_ff, cand_in, other_ff, other_in;
   logic [COORD_W-1:0]  width_ff, width_in, height_ff, height_in;
   logic                side_ff, side_in, last_ff, last_in, keep_ff, keep_in;

   logic [AREA_W-1:0]   area_a_ff, area_a_in, area_b_ff, area_b_in, inter_ff, inter_in;

   logic                out_valid_ff, out_valid_in;
   box_type             out_box_ff, out_box_in;
   logic                out_kept_ff, out_kept_in, out_side_ff, out_side_in;
   logic                out_last_ff, out_last_in;

   // request fields
   logic [COORD_W-1:0]  in_cx, in_cy, in_w, in_h;
   logic [SCORE_W-1:0]  in_score;
   box_type             in_box;
   logic                in_side, in_cand, accept;

   // overlap window against the other side's box
   corner_type          win_l, win_t, win_r, win_b;
   logic signed [CORNER_W:0] win_w, win_h;
   logic [COORD_W-1:0]  oth_w, oth_h;
   logic [UNION_W-1:0]  union_area;

   // shared multiplier
   logic [SCORE_W-1:0]  mul_a;
   logic [UNION_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_p;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   assign in_cx    = req_tdata[COORD_W-1:0];
   assign in_cy    = req_tdata[2*COORD_W-1:COORD_W];
   assign in_w     = req_tdata[3*COORD_W-1:2*COORD_W];
   assign in_h     = req_tdata[4*COORD_W-1:3*COORD_W];
   assign in_score = req_tdata[REQ_DATA_W-1:4*COORD_W];

   always_comb begin
      in_box.left   = corner_type'({2'b00, in_cx}) - corner_type'({3'b000, in_w[COORD_W-1:1]});
      in_box.top    = corner_type'({2'b00, in_cy}) - corner_type'({3'b000, in_h[COORD_W-1:1]});
      in_box.right  = in_box.left + corner_type'({2'b00, in_w});
      in_box.bottom = in_box.top + corner_type'({2'b00, in_h});
      in_side = (in_cx[COORD_W-1:4] > boundary_ff);
      in_cand = (in_score > conf_thr_ff) && !(in_side ? right_taken_ff : left_taken_ff);
   end

   always_comb begin
      win_l = (cand_ff.left > other_ff.left) ? cand_ff.left : other_ff.left;
      win_t = (cand_ff.top > other_ff.top) ? cand_ff.top : other_ff.top;
      win_r = (cand_ff.right < other_ff.right) ? cand_ff.right : other_ff.right;
      win_b = (cand_ff.bottom < other_ff.bottom) ? cand_ff.bottom : other_ff.bottom;
      win_w = {win_r[CORNER_W-1], win_r} - {win_l[CORNER_W-1], win_l};
      win_h = {win_b[CORNER_W-1], win_b} - {win_t[CORNER_W-1], win_t};
      // a stored box spans its own width and height, which fit the coordinate width
      oth_w = COORD_W'(other_ff.right - other_ff.left);
      oth_h = COORD_W'(other_ff.bottom - other_ff.top);
      union_area = {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, inter_ff};
   end

   always_comb begin
      case (state_ff)
         S_AREA: begin
            mul_a = {2'b00, width_ff};
            mul_b = {15'd0, height_ff};
         end
         S_OTHER: begin
            mul_a = {2'b00, oth_w};
            mul_b = {15'd0, oth_h};
         end
         S_INTER: begin
            mul_a = {2'b00, win_w[COORD_W-1:0]};
            mul_b = {15'd0, win_h[COORD_W-1:0]};
         end
         S_UNION: begin
            mul_a = iou_thr_ff;
            mul_b = union_area;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      state_in       = state_ff;
      cand_in        = cand_ff;
      other_in       = other_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      side_in        = side_ff;
      last_in        = last_ff;
      keep_in        = keep_ff;
      area_a_in      = area_a_ff;
      area_b_in      = area_b_ff;
      inter_in       = inter_ff;
      left_box_in    = left_box_ff;
      right_box_in   = right_box_ff;
      left_taken_in  = left_taken_ff;
      right_taken_in = right_taken_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_box_in     = out_box_ff;
      out_kept_in    = out_kept_ff;
      out_side_in    = out_side_ff;
      out_last_in    = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cand_in   = in_box;
               other_in  = in_side ? left_box_ff : right_box_ff;
               width_in  = in_w;
               height_in = in_h;
               side_in   = in_side;
               last_in   = req_tlast;
               keep_in   = in_cand;
               // only the opposite side can hold a box to test against
               if (in_cand && (in_side ? left_taken_ff : right_taken_ff)) begin
                  state_in = S_AREA;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_AREA: begin
            area_a_in = mul_p[AREA_W-1:0];
            state_in  = S_OTHER;
         end
         S_OTHER: begin
            area_b_in = mul_p[AREA_W-1:0];
            state_in  = S_INTER;
         end
         S_INTER: begin
            inter_in = mul_p[AREA_W-1:0];
            if ((win_w > 0) && (win_h > 0)) begin
               state_in = S_UNION;
            end else begin
               state_in = S_OUT;
            end
         end
         S_UNION: begin
            if (PROD_W'({inter_ff, 16'd0}) > mul_p) begin
               keep_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_box_in   = cand_ff;
               out_kept_in  = keep_ff;
               out_side_in  = side_ff;
               out_last_in  = last_ff;
               if (keep_ff) begin
                  if (side_ff) begin
                     right_box_in   = cand_ff;
                     right_taken_in = 1'b1;
                  end else begin
                     left_box_in   = cand_ff;
                     left_taken_in = 1'b1;
                  end
               end
               if (last_ff) begin
                  left_box_in    = '0;
                  right_box_in   = '0;
                  left_taken_in  = 1'b0;
                  right_taken_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         conf_thr_ff    <= 16'd32768;
         iou_thr_ff     <= 16'd29491;
         boundary_ff    <= 10'd320;
         left_taken_ff  <= 1'b0;
         right_taken_ff <= 1'b0;
         left_box_ff    <= '0;
         right_box_ff   <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         left_taken_ff  <= left_taken_in;
         right_taken_ff <= right_taken_in;
         left_box_ff    <= left_box_in;
         right_box_ff   <= right_box_in;
         out_valid_ff   <= out_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CONF_THRESHOLD: conf_thr_ff <= csr_data;
               CSR_IOU_THRESHOLD:  iou_thr_ff  <= csr_data;
               CSR_SIDE_BOUNDARY:  boundary_ff <= csr_data[BOUND_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      other_ff    <= other_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      side_ff     <= side_in;
      last_ff     <= last_in;
      keep_ff     <= keep_in;
      area_a_ff   <= area_a_in;
      area_b_ff   <= area_b_in;
      inter_ff    <= inter_in;
      out_box_ff  <= out_box_in;
      out_kept_ff <= out_kept_in;
      out_side_ff <= out_side_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_box_ff;
   assign rsp_tuser  = {out_side_ff, out_kept_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
